// ----- hw/rtl/double_ended_queue_core_macros.svh -----
// Assertion macros shared by the deque checker.
`ifndef DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/dq_pkg.sv -----
// Package: deque payload types, operation and status codes, default depth.
package dq_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;

  typedef logic [KIND_W-1:0]          kind_t;
  typedef logic signed [VALUE_W-1:0]  value_t;
  typedef logic [STATUS_W-1:0]        status_t;

  localparam kind_t KIND_PUSH_FRONT = 3'd0;
  localparam kind_t KIND_PUSH_REAR  = 3'd1;
  localparam kind_t KIND_POP_FRONT  = 3'd2;
  localparam kind_t KIND_POP_REAR   = 3'd3;
  localparam kind_t KIND_DUMP       = 3'd4;

  localparam status_t STAT_OK         = 3'd0;
  localparam status_t STAT_UNDERFLOW  = 3'd1;
  localparam status_t STAT_OVERFLOW   = 3'd2;
  localparam status_t STAT_DUMP_ELEM  = 3'd3;
  localparam status_t STAT_DUMP_EMPTY = 3'd4;

endpackage

// ----- hw/rtl/dq_if.sv -----
// Interfaces: command channel and result channel of the deque.
interface dq_in_if;
  logic           valid;
  logic           ready;
  dq_pkg::kind_t  kind;
  dq_pkg::value_t value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface dq_out_if;
  logic            valid;
  logic            ready;
  dq_pkg::status_t status;
  dq_pkg::value_t  value_res;
  logic            last;

  modport source (output valid, output status, output value_res, output last, input ready);
  modport sink   (input valid, input status, input value_res, input last, output ready);
endinterface

// ----- hw/rtl/dq_ram.sv -----
// Element storage: one write port, one registered read port.
module dq_ram #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  dq_pkg::value_t wdata,
  input  logic           re,
  input  logic [AW-1:0]  raddr,
  output dq_pkg::value_t rdata
);

  dq_pkg::value_t mem [DEPTH];
  dq_pkg::value_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/dq_ctrl.sv -----
// Deque control: head and count, command decode, dump sequencer, result register.
module dq_ctrl #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  dq_in_if.sink          in_if,
  dq_out_if.source       out_if,
  output logic           mem_we,
  output logic [AW-1:0]  mem_waddr,
  output dq_pkg::value_t mem_wdata,
  output logic           mem_re,
  output logic [AW-1:0]  mem_raddr,
  input  dq_pkg::value_t mem_rdata
);

  localparam int SW = CW + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_POP  = 2'd1;
  localparam logic [1:0] ST_DUMP = 2'd2;

  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

  logic [1:0]      state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   dptr_r, dptr_nxt;
  logic [CW-1:0]   rem_r, rem_nxt;

  logic            out_valid_r, out_valid_nxt;
  dq_pkg::status_t out_status_r;
  dq_pkg::value_t  out_value_r;
  logic            out_last_r;

  logic            load;
  dq_pkg::status_t load_status;
  dq_pkg::value_t  load_value;
  logic            load_last;

  logic            out_free;
  logic            accept;
  logic [SW-1:0]   tail_sum;
  logic [AW-1:0]   head_inc;
  logic [AW-1:0]   head_dec;
  logic [AW-1:0]   rear_free;
  logic [AW-1:0]   rear_used;

  function automatic logic [AW-1:0] wrap_idx(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= DEPTH_S) ? s - DEPTH_S : s;
    return r[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] inc_idx(input logic [AW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  assign out_free = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == ST_IDLE) && out_free;
  assign accept = in_if.valid && in_if.ready;

  assign tail_sum  = SW'(head_r) + SW'(count_r);
  assign head_inc  = inc_idx(head_r);
  assign head_dec  = (head_r == '0) ? LAST_IDX : head_r - 1'b1;
  assign rear_free = wrap_idx(tail_sum);
  assign rear_used = wrap_idx(tail_sum - 1'b1);

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    dptr_nxt    = dptr_r;
    rem_nxt     = rem_r;
    mem_we      = 1'b0;
    mem_waddr   = rear_free;
    mem_wdata   = in_if.value;
    mem_re      = 1'b0;
    mem_raddr   = head_r;
    load        = 1'b0;
    load_status = dq_pkg::STAT_OK;
    load_value  = '0;
    load_last   = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_if.kind)
            dq_pkg::KIND_PUSH_FRONT, dq_pkg::KIND_PUSH_REAR: begin
              load = 1'b1;
              if (count_r == FULL_CNT) begin
                load_status = dq_pkg::STAT_OVERFLOW;
              end else begin
                mem_we    = 1'b1;
                count_nxt = count_r + 1'b1;
                if (in_if.kind == dq_pkg::KIND_PUSH_FRONT) begin
                  mem_waddr = head_dec;
                  head_nxt  = head_dec;
                end
              end
            end
            dq_pkg::KIND_POP_FRONT, dq_pkg::KIND_POP_REAR: begin
              if (count_r == '0) begin
                load        = 1'b1;
                load_status = dq_pkg::STAT_UNDERFLOW;
              end else begin
                mem_re    = 1'b1;
                count_nxt = count_r - 1'b1;
                state_nxt = ST_POP;
                if (in_if.kind == dq_pkg::KIND_POP_FRONT) begin
                  head_nxt = head_inc;
                end else begin
                  mem_raddr = rear_used;
                end
              end
            end
            dq_pkg::KIND_DUMP: begin
              if (count_r == '0) begin
                load        = 1'b1;
                load_status = dq_pkg::STAT_DUMP_EMPTY;
              end else begin
                mem_re    = 1'b1;
                dptr_nxt  = head_inc;
                rem_nxt   = count_r;
                state_nxt = ST_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP: begin
        if (out_free) begin
          load       = 1'b1;
          load_value = mem_rdata;
          state_nxt  = ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          load        = 1'b1;
          load_status = dq_pkg::STAT_DUMP_ELEM;
          load_value  = mem_rdata;
          load_last   = (rem_r == CW'(1));
          if (rem_r == CW'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = dptr_r;
            dptr_nxt  = inc_idx(dptr_r);
            rem_nxt   = rem_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = (out_valid_r && !out_if.ready) || load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dptr_r <= dptr_nxt;
    rem_r  <= rem_nxt;
    if (load) begin
      out_status_r <= load_status;
      out_value_r  <= load_value;
      out_last_r   <= load_last;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.status    = out_status_r;
  assign out_if.value_res = out_value_r;
  assign out_if.last      = out_last_r;

endmodule

// ----- hw/rtl/double_ended_queue_core.sv -----
// Top level: ring-buffer deque of signed 32-bit values.
//
//   channel | dir | handshake        | payload
//   --------+-----+------------------+------------------------------
//   in_if   | in  | valid / ready    | kind[2:0], value[31:0]
//   out_if  | out | valid / ready    | status[2:0], value_res[31:0], last
//
// Push, overflow, underflow, empty dump and unknown kinds keep the sequencer idle.
// Pop: the slot read is registered in the memory, then loaded as the result.
// Dump of N elements: after the first read the memory streams one element per
// cycle while out_if is free, reading the next slot as the current one transfers.
// Reset (rst_n low, synchronous) clears state, head, count and the result valid
// flag, not slot contents or payload. A stalled out_if holds the result register
// and the sequencer, and in_if.ready stays low until the result can move.
module double_ended_queue_core #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  dq_in_if.sink    in_if,
  dq_out_if.source out_if
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // slot memory port signals
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  dq_pkg::value_t mem_wdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;
  dq_pkg::value_t mem_rdata;

  // Decode commands, advance head and count, sequence dumps, hold the result.
  dq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Hold the elements; read data is registered and held until the next read.
  dq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ----- hw/rtl/dq_checker.sv -----
// Port-level checker for the deque core, with its bind.
`include "double_ended_queue_core_macros.svh"

module dq_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input dq_pkg::status_t out_status,
  input dq_pkg::value_t  out_value_res,
  input logic            out_last
);

  `DQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  `DQ_ASSERT_IMP(a_no_take_on_stall, out_valid && !out_ready, !in_ready, "command taken while result stalled")

  `DQ_ASSERT_IMP(a_single_is_last, out_valid && out_status != dq_pkg::STAT_DUMP_ELEM, out_last, "single result not marked last")

  `DQ_ASSERT_IMP(a_error_zero, out_valid && (out_status == dq_pkg::STAT_UNDERFLOW || out_status == dq_pkg::STAT_OVERFLOW || out_status == dq_pkg::STAT_DUMP_EMPTY), out_value_res == '0, "status result carries data")

  `DQ_ASSERT_IMP(a_status_range, out_valid, out_status <= dq_pkg::STAT_DUMP_EMPTY, "status code out of range")

endmodule

bind double_ended_queue_core dq_checker u_dq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_status    (out_if.status),
  .out_value_res (out_if.value_res),
  .out_last      (out_if.last)
);
